@@ rtl/core/biquad_pkg.sv @@
package biquad_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 3;
    localparam int STATE_WIDTH    = 32;
    localparam int PROD_WIDTH     = COEF_WIDTH + STATE_WIDTH;
    // Three-term sum of products, or the scaled sample less two products; two guard bits.
    localparam int ACC_WIDTH      = PROD_WIDTH + 2;

    // Register indexes on the configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_A2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_B1 = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEF_B2 = 3'd4;

    localparam logic signed [COEF_WIDTH-1:0] COEF_A_RESET =
        COEF_WIDTH'(1) <<< COEF_FRAC_BITS;

    // Microcode fields
    localparam logic [1:0] DSEL_D0 = 2'd0;
    localparam logic [1:0] DSEL_D1 = 2'd1;
    localparam logic [1:0] DSEL_T  = 2'd2;

    localparam logic [2:0] ACC_HOLD    = 3'd0;
    localparam logic [2:0] ACC_LOAD    = 3'd1;  // scaled sample plus rounding half
    localparam logic [2:0] ACC_ADD     = 3'd2;
    localparam logic [2:0] ACC_SUB     = 3'd3;
    localparam logic [2:0] ACC_ROUND_T = 3'd4;  // capture t, restart with rounding half

    localparam logic [1:0] COND_NONE = 2'd0;
    localparam logic [1:0] COND_IN   = 2'd1;    // advance on an accepted input beat
    localparam logic [1:0] COND_OUT  = 2'd2;    // advance when the output register is free

    localparam int NUM_STEPS  = 9;
    localparam int STEP_WIDTH = $clog2(NUM_STEPS);
    localparam logic [STEP_WIDTH-1:0] FIRST_STEP = STEP_WIDTH'(0);
    localparam logic [STEP_WIDTH-1:0] LAST_STEP  = STEP_WIDTH'(NUM_STEPS - 1);

    typedef struct packed {
        logic [CFG_INDEX_WIDTH-1:0] coef_sel;
        logic [1:0]                 data_sel;
        logic [2:0]                 acc_op;
        logic [1:0]                 cond;
        logic                       finish;   // write result, shift delays, jump to start
    } ucode_t;

    // Program: feedback sum, round to t, feedforward sum, round to y.
    // The product of a step lands in the product register and is
    // accumulated by the next step.
    function automatic ucode_t ucode_rom(input logic [STEP_WIDTH-1:0] step);
        ucode_t w;
        w = '{coef_sel: REG_COEF_A, data_sel: DSEL_D0, acc_op: ACC_HOLD,
              cond: COND_NONE, finish: 1'b0};
        unique case (step)
            4'd0: begin
                w.coef_sel = REG_COEF_B1; w.data_sel = DSEL_D0;
                w.acc_op = ACC_LOAD; w.cond = COND_IN;
            end
            4'd1: begin
                w.coef_sel = REG_COEF_B2; w.data_sel = DSEL_D1; w.acc_op = ACC_SUB;
            end
            4'd2: w.acc_op = ACC_SUB;
            4'd3: w.acc_op = ACC_ROUND_T;
            4'd4: begin
                w.coef_sel = REG_COEF_A; w.data_sel = DSEL_T;
            end
            4'd5: begin
                w.coef_sel = REG_COEF_A1; w.data_sel = DSEL_D0; w.acc_op = ACC_ADD;
            end
            4'd6: begin
                w.coef_sel = REG_COEF_A2; w.data_sel = DSEL_D1; w.acc_op = ACC_ADD;
            end
            4'd7: w.acc_op = ACC_ADD;
            4'd8: begin
                w.cond = COND_OUT; w.finish = 1'b1;
            end
            default: ;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/second_order_iir_biquad.sv @@
// Channel   | Handshake                 | Payload
// ----------+---------------------------+----------------------------------------
// input     | s_valid / s_ready         | s_in_sample (24b signed)
// result    | m_valid / m_ready         | m_out_sample (24b signed), m_clipped
// config    | cfg_wr_en (no wait)       | cfg_index (3b), cfg_wdata (19b)
//
// One beat runs through the idle/accept step and eight further microcode steps that
// share a single 19x32 multiplier over the five products.
// The multiplier is followed by a product register, so each product is
// accumulated by the step after the one that issues it.
// A finished result waits in the output register; the next beat is accepted
// meanwhile and only the last step stalls if that register is still full.
// aresetn is synchronous, active low: coefficients return to a=1.0, others 0,
// delay state clears and the sequencer returns to its first step.
module second_order_iir_biquad
    import biquad_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_in_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_out_sample,
    output logic                              m_clipped,
    input  logic                              cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [COEF_WIDTH-1:0]             cfg_wdata
);

    localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
        ACC_WIDTH'(1) <<< (COEF_FRAC_BITS - 1);

    // Coefficient registers
    logic signed [COEF_WIDTH-1:0] coef_a_reg, coef_a1_reg, coef_a2_reg;
    logic signed [COEF_WIDTH-1:0] coef_b1_reg, coef_b2_reg;

    // Datapath registers
    logic signed [STATE_WIDTH-1:0]  d0_reg, d1_reg, t_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic                           clip_t_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_clipped_reg;
    logic                           m_valid_reg, m_valid_next;

    // Sequencer
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    ucode_t                uw;
    logic                  advance;

    logic signed [COEF_WIDTH-1:0]  coef_mux;
    logic signed [STATE_WIDTH-1:0] data_mux;
    logic signed [ACC_WIDTH-1:0]   prod_ext, sample_ext, acc_shift;
    logic                          t_ovf, y_ovf;
    logic signed [STATE_WIDTH-1:0] t_sat;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    assign uw = ucode_rom(step_reg);

    // Step advance condition from the control word
    always_comb begin
        unique case (uw.cond)
            COND_IN:  advance = s_valid;
            COND_OUT: advance = !m_valid_reg || m_ready;
            default:  advance = 1'b1;
        endcase
    end

    assign s_ready = (uw.cond == COND_IN);
    assign m_valid = m_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_clipped = out_clipped_reg;

    always_comb begin
        if (!advance) begin
            step_next = step_reg;
        end else if (uw.finish) begin
            step_next = FIRST_STEP;
        end else begin
            step_next = step_reg + STEP_WIDTH'(1);
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        unique case (uw.coef_sel)
            REG_COEF_A:  coef_mux = coef_a_reg;
            REG_COEF_A1: coef_mux = coef_a1_reg;
            REG_COEF_A2: coef_mux = coef_a2_reg;
            REG_COEF_B1: coef_mux = coef_b1_reg;
            REG_COEF_B2: coef_mux = coef_b2_reg;
            default:     coef_mux = coef_a_reg;
        endcase
        unique case (uw.data_sel)
            DSEL_D1: data_mux = d1_reg;
            DSEL_T:  data_mux = t_reg;
            default: data_mux = d0_reg;
        endcase
    end

    assign prod_ext   = {{(ACC_WIDTH-PROD_WIDTH){prod_reg[PROD_WIDTH-1]}}, prod_reg};
    assign sample_ext = {{(ACC_WIDTH-SAMPLE_WIDTH-COEF_FRAC_BITS){s_in_sample[SAMPLE_WIDTH-1]}},
                         s_in_sample, COEF_FRAC_BITS'(0)};

    // Floor shift of the accumulator; the rounding half was preloaded.
    assign acc_shift = acc_reg >>> COEF_FRAC_BITS;

    // Overflow when the bits above the target sign bit disagree with it
    assign t_ovf = !((&acc_shift[ACC_WIDTH-1:STATE_WIDTH-1]) ||
                     !(|acc_shift[ACC_WIDTH-1:STATE_WIDTH-1]));
    assign y_ovf = !((&acc_shift[ACC_WIDTH-1:SAMPLE_WIDTH-1]) ||
                     !(|acc_shift[ACC_WIDTH-1:SAMPLE_WIDTH-1]));

    always_comb begin
        if (t_ovf) begin
            t_sat = {acc_shift[ACC_WIDTH-1], {(STATE_WIDTH-1){!acc_shift[ACC_WIDTH-1]}}};
        end else begin
            t_sat = acc_shift[STATE_WIDTH-1:0];
        end
        if (y_ovf) begin
            y_sat = {acc_shift[ACC_WIDTH-1], {(SAMPLE_WIDTH-1){!acc_shift[ACC_WIDTH-1]}}};
        end else begin
            y_sat = acc_shift[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (advance) begin
            unique case (uw.acc_op)
                ACC_LOAD:    acc_next = sample_ext + ROUND_HALF;
                ACC_ADD:     acc_next = acc_reg + prod_ext;
                ACC_SUB:     acc_next = acc_reg - prod_ext;
                ACC_ROUND_T: acc_next = ROUND_HALF;
                default:     acc_next = acc_reg;
            endcase
        end
    end

    always_comb begin
        if (advance && uw.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= FIRST_STEP;
            m_valid_reg <= 1'b0;
            d0_reg      <= '0;
            d1_reg      <= '0;
            coef_a_reg  <= COEF_A_RESET;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (advance && uw.finish) begin
                // shift the delay line
                d1_reg <= d0_reg;
                d0_reg <= t_reg;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_COEF_A:  coef_a_reg  <= cfg_wdata;
                    REG_COEF_A1: coef_a1_reg <= cfg_wdata;
                    REG_COEF_A2: coef_a2_reg <= cfg_wdata;
                    REG_COEF_B1: coef_b1_reg <= cfg_wdata;
                    REG_COEF_B2: coef_b2_reg <= cfg_wdata;
                    default: ;  // drop writes beyond the register list
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= coef_mux * data_mux;
        acc_reg  <= acc_next;
        if (advance && uw.acc_op == ACC_ROUND_T) begin
            t_reg      <= t_sat;
            clip_t_reg <= t_ovf;
        end
        if (advance && uw.finish) begin
            out_sample_reg  <= y_sat;
            out_clipped_reg <= clip_t_reg || y_ovf;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= LAST_STEP)
        else $error("sequencer step out of program range");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> step_reg == FIRST_STEP + STEP_WIDTH'(1))
        else $error("accepted beat did not start the program");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(step_reg) == LAST_STEP)
        else $error("result raised outside the last step");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg == LAST_STEP && m_valid && !m_ready |=> step_reg == LAST_STEP)
        else $error("last step left while output register full");
`endif

endmodule

@@ dv/second_order_iir_biquad_test.sv @@
typedef logic signed [biquad_pkg::SAMPLE_WIDTH-1:0] sample_t;
typedef logic signed [biquad_pkg::COEF_WIDTH-1:0]   coef_t;

typedef struct packed {
    sample_t out_sample;
    logic    clipped;
} filter_out_t;

// Bit-exact model of the direct form II section plus the queue of outputs it owes.
class biquad_filter_model;
    localparam int     FRAC        = biquad_pkg::COEF_FRAC_BITS;
    localparam longint STATE_HI    = (longint'(1) <<< (biquad_pkg::STATE_WIDTH - 1)) - 1;
    localparam longint STATE_LO    = -(longint'(1) <<< (biquad_pkg::STATE_WIDTH - 1));
    localparam longint SAMPLE_HI   = (longint'(1) <<< (biquad_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_LO   = -(longint'(1) <<< (biquad_pkg::SAMPLE_WIDTH - 1));
    localparam int     MAX_REPORTS = 10;

    coef_t       coef [5];
    longint      delay_newer;
    longint      delay_older;
    filter_out_t pending_outputs [$];
    int          outputs_seen;
    int          mismatches;

    function new();
        coef[biquad_pkg::REG_COEF_A]  = biquad_pkg::COEF_A_RESET;
        coef[biquad_pkg::REG_COEF_A1] = '0;
        coef[biquad_pkg::REG_COEF_A2] = '0;
        coef[biquad_pkg::REG_COEF_B1] = '0;
        coef[biquad_pkg::REG_COEF_B2] = '0;
        delay_newer  = 0;
        delay_older  = 0;
        outputs_seen = 0;
        mismatches   = 0;
    endfunction

    // Writes to spare indexes are dropped, as in the block.
    function void set_coef(logic [biquad_pkg::CFG_INDEX_WIDTH-1:0] idx, coef_t value);
        if (idx <= biquad_pkg::REG_COEF_B2)
            coef[idx] = value;
    endfunction

    // Round half up: add one half LSB, then floor.
    function longint round_half_up(longint acc);
        return (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function void take_sample(sample_t x);
        longint      acc;
        longint      t;
        longint      y;
        bit          hit;
        filter_out_t res;
        hit = 1'b0;
        acc = (longint'(x) <<< FRAC)
            - longint'(coef[biquad_pkg::REG_COEF_B1]) * delay_newer
            - longint'(coef[biquad_pkg::REG_COEF_B2]) * delay_older;
        t = round_half_up(acc);
        if (t > STATE_HI) begin
            t = STATE_HI;
            hit = 1'b1;
        end else if (t < STATE_LO) begin
            t = STATE_LO;
            hit = 1'b1;
        end
        acc = longint'(coef[biquad_pkg::REG_COEF_A])  * t
            + longint'(coef[biquad_pkg::REG_COEF_A1]) * delay_newer
            + longint'(coef[biquad_pkg::REG_COEF_A2]) * delay_older;
        y = round_half_up(acc);
        if (y > SAMPLE_HI) begin
            y = SAMPLE_HI;
            hit = 1'b1;
        end else if (y < SAMPLE_LO) begin
            y = SAMPLE_LO;
            hit = 1'b1;
        end
        delay_older = delay_newer;
        delay_newer = t;
        res.out_sample = sample_t'(y);
        res.clipped    = hit;
        pending_outputs.push_back(res);
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    function void check_output(sample_t got_y, logic got_clip);
        filter_out_t want;
        if (pending_outputs.size() == 0) begin
            flag($sformatf("output with nothing awaited: y=%0d clipped=%0b", got_y, got_clip));
            return;
        end
        want = pending_outputs.pop_front();
        if (got_y !== want.out_sample)
            flag($sformatf("output %0d out_sample: expected %0d, got %0d",
                           outputs_seen, want.out_sample, got_y));
        if (got_clip !== want.clipped)
            flag($sformatf("output %0d clipped: expected %0b, got %0b",
                           outputs_seen, want.clipped, got_clip));
        outputs_seen++;
    endfunction

    function int pending();
        return pending_outputs.size();
    endfunction

    function bit all_matched();
        if (pending_outputs.size() != 0)
            $display("outputs never delivered: %0d", pending_outputs.size());
        return mismatches == 0 && pending_outputs.size() == 0;
    endfunction
endclass

module second_order_iir_biquad_test;
    import biquad_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 12;      // slack after the last output is taken
    localparam int LONG_HOLD     = 400;     // receiver hold-off that backs up the block
    localparam int RUN_LIMIT     = 1000000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 115;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_FIRST = REG_COEF_B2 + 1'b1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LAST  = '1;

    localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(1 << (SAMPLE_WIDTH - 1));
    localparam coef_t   COEF_MAX   = coef_t'((1 << (COEF_WIDTH - 1)) - 1);
    localparam coef_t   COEF_MIN   = coef_t'(1 << (COEF_WIDTH - 1));
    localparam coef_t   COEF_ONE   = coef_t'(1 << COEF_FRAC_BITS);
    localparam coef_t   COEF_HALF  = coef_t'(1 << (COEF_FRAC_BITS - 1));

    // Butterworth sections, Q3.16, feedback terms given with the sign the block subtracts.
    localparam coef_t LP_A  = coef_t'(1317);
    localparam coef_t LP_A1 = coef_t'(2634);
    localparam coef_t LP_A2 = coef_t'(1317);
    localparam coef_t HP_A  = coef_t'(52469);
    localparam coef_t HP_A1 = coef_t'(-104938);
    localparam coef_t HP_A2 = coef_t'(52469);
    localparam coef_t BW_B1 = coef_t'(-102300);
    localparam coef_t BW_B2 = coef_t'(42034);

    logic    aclk         = 1'b0;
    logic    aresetn      = 1'b0;
    logic    s_valid      = 1'b0;
    logic    s_ready;
    sample_t s_in_sample  = '0;
    logic    m_valid;
    logic    m_ready      = 1'b0;
    sample_t m_out_sample;
    logic    m_clipped;
    logic    cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_COEF_A;
    logic [COEF_WIDTH-1:0]      cfg_wdata = '0;

    biquad_filter_model filter_model = new();

    // Main sequence raises these; the receiver only reads them.
    bit no_idle       = 1'b0;
    int hold_requests = 0;

    second_order_iir_biquad dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_sample  (s_in_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_clipped    (m_clipped),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Mostly back to back, now and then a short pause, rarely a long one.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            6, 7:    return sample_t'(int'($urandom_range(0, 2000)) - 1000);
            8:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            9:       return sample_t'(int'($urandom_range(0, 6)) - 3);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t random_coef();
        case ($urandom_range(0, 3))
            0:       return coef_t'($urandom);
            3:       return '0;
            default: return coef_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Sample every handshake on the pre-edge values; check outputs before
    // noting the new beat (an output can never belong to the same-edge input).
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                filter_model.check_output(m_out_sample, m_clipped);
            if (s_valid && s_ready)
                filter_model.take_sample(s_in_sample);
        end
    end

    // Receiver: stall, then a burst of ready; honor a long hold-off on request.
    int rx_burst = 0;
    int rx_stall = 0;
    int holds_done = 0;

    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (hold_requests != holds_done) begin
            holds_done++;
            rx_stall = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            m_ready <= 1'b1;
        end else begin
            rx_burst = $urandom_range(0, 23);
            rx_stall = idle_gap();
            m_ready <= (rx_stall == 0);
            if (rx_stall > 0)
                rx_stall--;
        end
    end

    // Offer one beat; keep valid high across back-to-back beats.
    task automatic send_sample(input sample_t x);
        int gap;
        gap = no_idle ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_sample <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold until every owed output is out and the sequencer is done.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (filter_model.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leave the enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input coef_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        filter_model.set_coef(idx, value);
    endtask

    task automatic write_spare();
        write_reg(CFG_INDEX_WIDTH'(REG_SPARE_FIRST +
                      $urandom_range(0, REG_SPARE_LAST - REG_SPARE_FIRST)),
                  coef_t'($urandom));
    endtask

    // Load all five coefficients, sometimes followed by a junk write to a spare index.
    task automatic load_coefs(input coef_t a, input coef_t a1, input coef_t a2,
                              input coef_t b1, input coef_t b2);
        write_reg(REG_COEF_A,  a);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
        write_reg(REG_COEF_B1, b1);
        write_reg(REG_COEF_B2, b2);
        if ($urandom_range(0, 1))
            write_spare();
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        sample_t corners [7];
        corners = '{'0, sample_t'(1), sample_t'(-1), SAMPLE_MAX, SAMPLE_MIN,
                    sample_t'('h555555), sample_t'('haaaaaa)};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Spare indexes must not disturb the reset unity-gain pass-through.
        write_spare();
        write_spare();
        write_spare();
        cfg_wr_en <= 1'b0;
        foreach (corners[i])
            send_sample(corners[i]);

        // Half gain: exact halves round up, so -1 gives 0 and 1 gives 1.
        wait_idle();
        load_coefs(COEF_HALF, '0, '0, '0, '0);
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(3));
        send_sample(sample_t'(-3));

        // Near-4x gain: full-scale samples clip the output.
        wait_idle();
        load_coefs(COEF_MAX, '0, '0, '0, '0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(1000));

        // Strong feedback: the state swings in sign and grows until it clips both ways.
        wait_idle();
        load_coefs(COEF_ONE, '0, '0, COEF_MAX, '0);
        repeat (8) send_sample(SAMPLE_MAX);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0, 7:    load_coefs(LP_A, LP_A1, LP_A2, BW_B1, BW_B2);
                1:       load_coefs(HP_A, HP_A1, HP_A2, BW_B1, BW_B2);
                3:       load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                5:       load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
                9:       load_coefs(COEF_ONE, '0, '0, '0, '0);
                default: load_coefs(random_coef(), random_coef(), random_coef(),
                                    random_coef(), random_coef());
            endcase
            // Stall the receiver for a long stretch while beats keep coming.
            if (p == 1)
                hold_requests++;
            no_idle = (p == 6);
            repeat (PHASE_ITEMS) send_sample(random_sample());
        end
        no_idle = 1'b0;

        wait_idle();
        if (filter_model.all_matched())
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    int cycle_count = 0;

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
